@@ design/assert_macros.svh @@
// Assertion macros for the tokenizer RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that also runs during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/xtt_pkg.sv @@
// Package for the XML tag event tokenizer: byte codes, phase and event
// codes, depth limit and the result record. No dependencies.
package xtt_pkg;

    localparam logic [7:0] MAX_DEPTH = 8'd255;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] PH_TEXT  = 3'd0;
    localparam logic [2:0] PH_OPEN  = 3'd1;
    localparam logic [2:0] PH_SNAME = 3'd2;
    localparam logic [2:0] PH_SREST = 3'd3;
    localparam logic [2:0] PH_ENAME = 3'd4;
    localparam logic [2:0] PH_EREST = 3'd5;
    localparam logic [2:0] PH_SKIP  = 3'd6;

    localparam logic [2:0] EV_TEXT     = 3'd0;
    localparam logic [2:0] EV_TEXT_END = 3'd1;
    localparam logic [2:0] EV_NAME     = 3'd2;
    localparam logic [2:0] EV_START    = 3'd3;
    localparam logic [2:0] EV_END      = 3'd4;
    localparam logic [2:0] EV_DONE     = 3'd5;
    localparam logic [2:0] EV_ERROR    = 3'd6;

    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] data;
        logic [7:0] depth;
        logic       last;
    } result_t;

endpackage

@@ design/xml_tag_event_tokenizer_top.sv @@
// Each accepted document byte yields zero to three events together: the
// tokenizer state updates and the events land in a three-entry result buffer
// that drains one event per cycle while out_ready is high. A byte is taken
// whenever the buffer is empty or its last event is being taken in the same cycle,
// so bytes stream at one per cycle while each causes at most one event and
// out_ready is high; extra events hold back the next byte. No startup sequence after reset.
// Top level of the XML tag event tokenizer; uses xtt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xml_tag_event_tokenizer_top
    import xtt_pkg::*;
#(
    parameter logic [7:0] DEPTH_LIMIT = MAX_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] doc_byte,
    input  logic       end_of_doc,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_res,
    output logic [7:0] event_byte,
    output logic [7:0] nest_depth,
    output logic       last_in_run
);

    logic [2:0] phase_reg, phase_next;
    logic [7:0] level_reg, level_next;
    logic       text_pending_reg, text_pending_next;
    logic       slash_reg, slash_next;
    logic       failed_reg, failed_next;

    result_t    buf_reg [3];
    logic [1:0] cnt_reg;

    result_t    res [3];
    logic [1:0] n;
    logic       ok;
    logic       open_req, close_req;
    logic       in_fire, out_fire;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign in_ready  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    assign event_res   = buf_reg[0].ev;
    assign event_byte  = buf_reg[0].data;
    assign nest_depth  = buf_reg[0].depth;
    assign last_in_run = buf_reg[0].last;

    always_comb
    begin
        phase_next        = phase_reg;
        level_next        = level_reg;
        text_pending_next = text_pending_reg;
        slash_next        = slash_reg;
        failed_next       = failed_reg;
        ok                = 1'b1;
        open_req          = 1'b0;
        close_req         = 1'b0;
        n                 = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '{ev: EV_TEXT, data: 8'd0, depth: 8'd0, last: 1'b0};
        end

        if (!failed_reg)
        begin
            case (phase_reg)
                PH_TEXT:
                begin
                    if (doc_byte == CH_LT)
                    begin
                        if (text_pending_reg)
                        begin
                            res[n] = '{ev: EV_TEXT_END, data: 8'd0, depth: level_reg,
                                       last: 1'b0};
                            n = n + 2'd1;
                        end
                        text_pending_next = 1'b0;
                        phase_next        = PH_OPEN;
                    end
                    else
                    begin
                        res[n] = '{ev: EV_TEXT, data: doc_byte, depth: level_reg,
                                   last: 1'b0};
                        n = n + 2'd1;
                        text_pending_next = 1'b1;
                    end
                end
                PH_OPEN:
                begin
                    slash_next = 1'b0;
                    if (doc_byte == CH_QUEST || doc_byte == CH_BANG)
                        phase_next = PH_SKIP;
                    else if (doc_byte == CH_SLASH)
                        phase_next = PH_ENAME;
                    else if (doc_byte == CH_GT)
                    begin
                        open_req   = 1'b1;
                        phase_next = PH_TEXT;
                    end
                    else if (doc_byte == CH_SPACE)
                        phase_next = PH_SREST;
                    else
                    begin
                        res[n] = '{ev: EV_NAME, data: doc_byte, depth: level_reg,
                                   last: 1'b0};
                        n = n + 2'd1;
                        phase_next = PH_SNAME;
                    end
                end
                PH_SNAME:
                begin
                    if (doc_byte == CH_GT)
                    begin
                        open_req   = 1'b1;
                        phase_next = PH_TEXT;
                    end
                    else if (doc_byte == CH_SPACE || doc_byte == CH_SLASH)
                    begin
                        slash_next = (doc_byte == CH_SLASH);
                        phase_next = PH_SREST;
                    end
                    else
                    begin
                        res[n] = '{ev: EV_NAME, data: doc_byte, depth: level_reg,
                                   last: 1'b0};
                        n = n + 2'd1;
                    end
                end
                PH_SREST:
                begin
                    if (doc_byte == CH_GT)
                    begin
                        open_req   = 1'b1;
                        close_req  = slash_reg;
                        slash_next = 1'b0;
                        phase_next = PH_TEXT;
                    end
                end
                PH_ENAME:
                begin
                    if (doc_byte == CH_GT)
                    begin
                        close_req  = 1'b1;
                        phase_next = PH_TEXT;
                    end
                    else if (doc_byte == CH_SPACE)
                        phase_next = PH_EREST;
                    else
                    begin
                        res[n] = '{ev: EV_NAME, data: doc_byte, depth: level_reg,
                                   last: 1'b0};
                        n = n + 2'd1;
                    end
                end
                PH_EREST:
                begin
                    if (doc_byte == CH_GT)
                    begin
                        close_req  = 1'b1;
                        phase_next = PH_TEXT;
                    end
                end
                default:
                begin
                    if (doc_byte == CH_GT)
                        phase_next = PH_TEXT;
                end
            endcase

            if (open_req)
            begin
                if (level_next >= DEPTH_LIMIT)
                    ok = 1'b0;
                else
                begin
                    level_next = level_next + 8'd1;
                    res[n] = '{ev: EV_START, data: 8'd0, depth: level_next, last: 1'b0};
                    n = n + 2'd1;
                end
            end
            if (ok && close_req)
            begin
                if (level_next == 8'd0)
                    ok = 1'b0;
                else
                begin
                    level_next = level_next - 8'd1;
                    res[n] = '{ev: EV_END, data: 8'd0, depth: level_next, last: 1'b0};
                    n = n + 2'd1;
                end
            end

            if (!ok)
            begin
                res[0] = '{ev: EV_ERROR, data: 8'd0, depth: level_next, last: 1'b0};
                n = 2'd1;
                failed_next = 1'b1;
            end
            else if (end_of_doc)
            begin
                if (phase_next != PH_TEXT || text_pending_next)
                    res[n] = '{ev: EV_ERROR, data: 8'd0, depth: level_next, last: 1'b0};
                else
                    res[n] = '{ev: EV_DONE, data: 8'd0, depth: level_next, last: 1'b0};
                n = n + 2'd1;
            end

            if (n != 2'd0)
                res[n - 2'd1].last = 1'b1;
        end

        // end of document returns everything to the reset state
        if (end_of_doc)
        begin
            phase_next        = PH_TEXT;
            level_next        = 8'd0;
            text_pending_next = 1'b0;
            slash_next        = 1'b0;
            failed_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_TEXT;
            level_reg        <= 8'd0;
            text_pending_reg <= 1'b0;
            slash_reg        <= 1'b0;
            failed_reg       <= 1'b0;
            cnt_reg          <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg        <= phase_next;
                level_reg        <= level_next;
                text_pending_reg <= text_pending_next;
                slash_reg        <= slash_next;
                failed_reg       <= failed_next;
                cnt_reg          <= n;
            end
            else if (out_fire)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // result buffer: head at entry 0, shifts on each taken result unless a new byte is accepted
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_reg[0] <= res[0];
            buf_reg[1] <= res[1];
            buf_reg[2] <= res[2];
        end
        else if (out_fire)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

    `ASSERT_CLK(a_run_contiguous, out_fire && !last_in_run |=> out_valid, "event run broken")
    `ASSERT_CLK(a_failed_silent, in_fire && failed_reg |=> !out_valid, "event after error")
    `ASSERT_CLK(a_error_last, out_valid && event_res == EV_ERROR |-> last_in_run, "error not last")
    `ASSERT_CLK(a_depth_limit, out_valid |-> nest_depth <= DEPTH_LIMIT, "depth over limit")

endmodule

@@ verif/xtt_event_checker.sv @@
// Event checker for the XML tag event tokenizer: watches the byte and event channels,
// predicts the event stream of every accepted byte and compares field by field.
// Depends on xtt_pkg for byte, phase and event codes and the result record.
module xtt_event_checker
    import xtt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] doc_byte,
    input  logic       end_of_doc,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] event_res,
    input  logic [7:0] event_byte,
    input  logic [7:0] nest_depth,
    input  logic       last_in_run,
    output int         fail_count,
    output int         pending_count
);

    // tokenizer state as the predictor sees it
    logic [2:0] tag_state;
    logic [7:0] nest_lvl;
    logic       in_text_run;
    logic       self_close;
    logic       doc_failed;

    result_t    byte_evs[$];     // events caused by the current byte
    result_t    due_events[$];   // predicted events not yet seen on the output
    result_t    want;
    result_t    got;
    int         mismatches;

    function automatic void clear_state();
        tag_state   = PH_TEXT;
        nest_lvl    = 8'd0;
        in_text_run = 1'b0;
        self_close  = 1'b0;
        doc_failed  = 1'b0;
    endfunction

    function automatic void add_event(input logic [2:0] ev, input logic [7:0] data);
        result_t e;
        e.ev    = ev;
        e.data  = data;
        e.depth = nest_lvl;
        e.last  = 1'b0;
        byte_evs.push_back(e);
    endfunction

    function automatic bit enter_element();
        if (nest_lvl >= MAX_DEPTH)
            return 1'b0;
        nest_lvl = nest_lvl + 8'd1;
        add_event(EV_START, 8'h00);
        return 1'b1;
    endfunction

    function automatic bit leave_element();
        if (nest_lvl == 8'd0)
            return 1'b0;
        nest_lvl = nest_lvl - 8'd1;
        add_event(EV_END, 8'h00);
        return 1'b1;
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic eod);
        bit ok;
        ok = 1'b1;
        byte_evs.delete();
        // after an error everything up to the end-of-document byte is dropped
        if (doc_failed)
        begin
            if (eod)
                clear_state();
            return;
        end
        case (tag_state)
            PH_TEXT:
            begin
                if (b == CH_LT)
                begin
                    if (in_text_run)
                        add_event(EV_TEXT_END, 8'h00);
                    in_text_run = 1'b0;
                    tag_state   = PH_OPEN;
                end
                else
                begin
                    add_event(EV_TEXT, b);
                    in_text_run = 1'b1;
                end
            end
            PH_OPEN:
            begin
                self_close = 1'b0;
                if (b == CH_QUEST || b == CH_BANG)
                    tag_state = PH_SKIP;
                else if (b == CH_SLASH)
                    tag_state = PH_ENAME;
                else if (b == CH_GT)
                begin
                    ok        = enter_element();
                    tag_state = PH_TEXT;
                end
                else if (b == CH_SPACE)
                    tag_state = PH_SREST;
                else
                begin
                    add_event(EV_NAME, b);
                    tag_state = PH_SNAME;
                end
            end
            PH_SNAME:
            begin
                if (b == CH_GT)
                begin
                    ok        = enter_element();
                    tag_state = PH_TEXT;
                end
                else if (b == CH_SPACE || b == CH_SLASH)
                begin
                    self_close = (b == CH_SLASH);
                    tag_state  = PH_SREST;
                end
                else
                    add_event(EV_NAME, b);
            end
            PH_SREST:
            begin
                if (b == CH_GT)
                begin
                    ok = enter_element();
                    if (ok && self_close)
                        ok = leave_element();
                    self_close = 1'b0;
                    tag_state  = PH_TEXT;
                end
            end
            PH_ENAME:
            begin
                if (b == CH_GT)
                begin
                    ok        = leave_element();
                    tag_state = PH_TEXT;
                end
                else if (b == CH_SPACE)
                    tag_state = PH_EREST;
                else
                    add_event(EV_NAME, b);
            end
            PH_EREST:
            begin
                if (b == CH_GT)
                begin
                    ok        = leave_element();
                    tag_state = PH_TEXT;
                end
            end
            default:
            begin
                if (b == CH_GT)
                    tag_state = PH_TEXT;
            end
        endcase

        if (!ok)
        begin
            byte_evs.delete();
            add_event(EV_ERROR, 8'h00);
            doc_failed = 1'b1;
        end
        else if (eod)
            add_event((tag_state != PH_TEXT || in_text_run) ? EV_ERROR : EV_DONE, 8'h00);
        if (eod)
            clear_state();

        if (byte_evs.size() > 0)
            byte_evs[byte_evs.size() - 1].last = 1'b1;
        foreach (byte_evs[i])
            due_events.push_back(byte_evs[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            due_events.delete();
            mismatches    = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                tokenize_byte(doc_byte, end_of_doc);
            if (out_valid && out_ready)
            begin
                got.ev    = event_res;
                got.data  = event_byte;
                got.depth = nest_depth;
                got.last  = last_in_run;
                if (due_events.size() == 0)
                begin
                    $error("event with nothing predicted: event_res %0d", got.ev);
                    mismatches++;
                end
                else
                begin
                    want = due_events.pop_front();
                    if (got.ev !== want.ev)
                    begin
                        $error("event_res: expected %0d, got %0d", want.ev, got.ev);
                        mismatches++;
                    end
                    if (got.data !== want.data)
                    begin
                        $error("event_byte: expected %0d, got %0d", want.data, got.data);
                        mismatches++;
                    end
                    if (got.depth !== want.depth)
                    begin
                        $error("nest_depth: expected %0d, got %0d", want.depth, got.depth);
                        mismatches++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_in_run: expected %0d, got %0d", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            fail_count    <= mismatches;
            pending_count <= due_events.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the XML tag event tokenizer: clock, reset, byte stimulus,
// result-side stalls and the verdict. Uses xtt_pkg and xtt_event_checker.
module tb_top;
    import xtt_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] doc_byte = 8'h00;
    logic       end_of_doc = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] event_res;
    logic [7:0] event_byte;
    logic [7:0] nest_depth;
    logic       last_in_run;

    int fail_count;
    int pending_count;
    int n_sent = 0;
    int in_calm = 0;
    int out_calm = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    xml_tag_event_tokenizer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .doc_byte   (doc_byte),
        .end_of_doc (end_of_doc),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .event_byte (event_byte),
        .nest_depth (nest_depth),
        .last_in_run(last_in_run)
    );

    xtt_event_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .doc_byte     (doc_byte),
        .end_of_doc   (end_of_doc),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .event_byte   (event_byte),
        .nest_depth   (nest_depth),
        .last_in_run  (last_in_run),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    // random idle gap per request, with occasional stretches of no idling
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(10, 30);
        return $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_LT) ? CH_GT : b;
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || b == CH_SLASH || b == CH_GT || b == CH_QUEST || b == CH_BANG);
        return b;
    endfunction

    function automatic logic [7:0] attr_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_GT);
        return b;
    endfunction

    // entered at the step where the previous request was taken
    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        doc_byte   <= b;
        end_of_doc <= eod;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
    endtask

    task automatic send_str(input string s, input logic eod);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eod && (i == s.len() - 1));
    endtask

    // mostly well-formed document with random content and a random ending
    task automatic gen_doc();
        logic [7:0] doc_bytes[$];
        int         open_tags;
        open_tags = 0;
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 9))
                3, 4:
                begin
                    doc_bytes.push_back(CH_LT);
                    repeat ($urandom_range(1, 3)) doc_bytes.push_back(name_byte());
                    if ($urandom_range(0, 2) == 0)
                    begin
                        doc_bytes.push_back(CH_SPACE);
                        repeat ($urandom_range(0, 3)) doc_bytes.push_back(attr_byte());
                        doc_bytes.push_back(CH_GT);
                        open_tags++;
                    end
                    else if ($urandom_range(0, 2) == 0)
                    begin
                        doc_bytes.push_back(CH_SLASH);
                        doc_bytes.push_back(CH_GT);
                    end
                    else
                    begin
                        doc_bytes.push_back(CH_GT);
                        open_tags++;
                    end
                end
                5, 6:
                begin
                    // an unmatched end tag now and then
                    if (open_tags > 0 || $urandom_range(0, 7) == 0)
                    begin
                        doc_bytes.push_back(CH_LT);
                        doc_bytes.push_back(CH_SLASH);
                        repeat ($urandom_range(0, 3)) doc_bytes.push_back(name_byte());
                        if ($urandom_range(0, 3) == 0)
                        begin
                            doc_bytes.push_back(CH_SPACE);
                            repeat ($urandom_range(0, 2)) doc_bytes.push_back(attr_byte());
                        end
                        doc_bytes.push_back(CH_GT);
                        if (open_tags > 0)
                            open_tags--;
                    end
                end
                7:
                begin
                    doc_bytes.push_back(CH_LT);
                    doc_bytes.push_back($urandom_range(0, 1) ? CH_QUEST : CH_BANG);
                    repeat ($urandom_range(0, 3)) doc_bytes.push_back(attr_byte());
                    doc_bytes.push_back(CH_GT);
                end
                8:
                begin
                    doc_bytes.push_back(CH_LT);
                    doc_bytes.push_back(CH_GT);
                    open_tags++;
                end
                default:
                    repeat ($urandom_range(1, 4)) doc_bytes.push_back(text_byte());
            endcase
        end
        case ($urandom_range(0, 7))
            0: doc_bytes.push_back(text_byte());
            1:
            begin
                doc_bytes.push_back(CH_LT);
                doc_bytes.push_back(name_byte());
            end
            default:
            begin
                doc_bytes.push_back(CH_LT);
                doc_bytes.push_back((open_tags > 0) ? CH_SLASH : CH_BANG);
                doc_bytes.push_back(CH_GT);
            end
        endcase
        foreach (doc_bytes[i])
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    endtask

    // markup-heavy junk with stray document ends, closed by an end byte
    task automatic gen_noise();
        logic [7:0] b;
        repeat ($urandom_range(4, 16))
        begin
            case ($urandom_range(0, 7))
                0: b = CH_LT;
                1: b = CH_GT;
                2: b = CH_SLASH;
                3: b = CH_QUEST;
                4: b = CH_BANG;
                5: b = CH_SPACE;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, $urandom_range(0, 11) == 0);
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // text extremes and '>' as text, start, end and self-closing tags
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_str("<a >", 1'b0);
        send_str("</a>", 1'b0);
        send_str("<c/>", 1'b1);
        // end tag at depth zero
        send_str("</>", 1'b1);
        // skipped tag, slash after a space is not self-closing, unclosed at end
        send_str("<?x><a />", 1'b1);
        // document ends inside a tag, then in text
        send_str("t<!-", 1'b1);
        send_str("x", 1'b1);

        while (n_sent < 170)
        begin
            if ($urandom_range(0, 4) == 0)
                gen_noise();
            else
                gen_doc();
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("[xml_tag_event_tokenizer_top] OK");
        else
            $display("[xml_tag_event_tokenizer_top] ERROR");
        $finish;
    end

    // result side: random stalls plus one long hold-off to back up the input
    initial
    begin
        int  gap;
        int  taken;
        bit  held_off;
        taken    = 0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && taken >= 60)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            gap = draw_gap(out_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin
        #(8 * 400_000);
        $display("[xml_tag_event_tokenizer_top] ERROR");
        $finish;
    end

endmodule
